[hdl/owsm_pkg.sv]
// Shared types and constants of the omni wheel speed mixer.
package owsm_pkg;

   localparam int CMD_W      = 16;              // command field width
   localparam int LIM_W      = 15;              // limit register width
   localparam int OUT_W      = 26;              // wheel speed field width
   localparam int Q_IN       = 14;              // fraction bits of the mix
   localparam int WHEEL_W    = 32;              // signed Q14 wheel value
   localparam int MAG_W      = 31;              // magnitude of a Q14 wheel value
   localparam int MUL_W      = MAG_W + LIM_W;   // magnitude times wheel limit
   localparam int MIX_STAGES = 5;

   localparam logic signed [CMD_W-1:0] SQRT3_Q14 = 16'sd28378;

   localparam logic [OUT_W-1:0] SPEED_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SPEED_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CSR_LIMIT_VX    = 2'd0,
      CSR_LIMIT_VY    = 2'd1,
      CSR_LIMIT_VW    = 2'd2,
      CSR_WHEEL_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LIM_W-1:0] limit_vx;
      logic [LIM_W-1:0] limit_vy;
      logic [LIM_W-1:0] limit_vw;
      logic [LIM_W-1:0] wheel_limit;
   } limits_type;

   // Wheel magnitudes, signs, largest magnitude and the scaling decision.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [MAG_W-1:0]      maxq;
      logic                  scale;
   } mix_type;

endpackage

[hdl/owsm_if.sv]
// Request and response channel interfaces of the omni wheel speed mixer.
interface owsm_req_if import owsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] cmd_vx;
   logic signed [CMD_W-1:0] cmd_vy;
   logic signed [CMD_W-1:0] cmd_vw;

   modport source (output valid, output cmd_vx, output cmd_vy, output cmd_vw, input ready);
   modport sink   (input valid, input cmd_vx, input cmd_vy, input cmd_vw, output ready);
endinterface

interface owsm_rsp_if import owsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] front_speed;
   logic signed [OUT_W-1:0] left_speed;
   logic signed [OUT_W-1:0] right_speed;
   logic                    was_scaled;

   modport source (output valid, output front_speed, output left_speed,
                   output right_speed, output was_scaled, input ready);
   modport sink   (input valid, input front_speed, input left_speed,
                   input right_speed, input was_scaled, output ready);
endinterface

[hdl/omni_wheel_speed_mixer_core.sv]
// Top level of the three-wheel omni chassis speed mixer.
//
// Turns a chassis velocity command (vx, vy, vw) into front, left and right
// wheel speeds for a three-wheel omni base with 60-degree geometry. Each
// command part is first clamped to +/- its limit register, then mixed in Q14
// (sqrt3 as 28378/16384); if the largest wheel magnitude is strictly above
// wheel_limit, all three wheels are scaled by wheel_limit/max so their ratios
// hold, and was_scaled is set. Results carry FRAC_BITS fraction bits,
// truncated toward zero, and saturate to the 26-bit range. The block is fully
// pipelined: unless back-pressure stalls it, a new command is taken on every
// cycle and one result comes out per cycle. The restoring divider resolves one
// quotient bit per stage in each of three parallel lanes. Each stage holds its
// item only while the stage after it is full, so bubbles close up under
// back-pressure and commands keep entering while a finished result waits in
// the output register. Write the limit registers only while the pipeline is
// empty.
module omni_wheel_speed_mixer_core import owsm_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   owsm_req_if.sink         req_chan,
   owsm_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [LIM_W-1:0] csr_wdata
);

   localparam int DEPTH = MIX_STAGES + LIM_W + FRAC_BITS + 2;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CHK_W = ((OUT_W > LIM_W + FRAC_BITS) ? OUT_W : LIM_W + FRAC_BITS) + 1;

   limits_type limits_ff, limits_in;

   logic    mix_valid;
   logic    mix_ready;
   mix_type mix_data;

   // Limit registers: reset to full range, written by index.
   always_comb begin
      limits_in = limits_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LIMIT_VX:    limits_in.limit_vx    = csr_wdata;
            CSR_LIMIT_VY:    limits_in.limit_vy    = csr_wdata;
            CSR_LIMIT_VW:    limits_in.limit_vw    = csr_wdata;
            CSR_WHEEL_LIMIT: limits_in.wheel_limit = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '1;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // Clamp, mix and find the largest wheel.
   owsm_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .cmd_vx    (req_chan.cmd_vx),
      .cmd_vy    (req_chan.cmd_vy),
      .cmd_vw    (req_chan.cmd_vw),
      .limits    (limits_ff),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   // Scale by wheel_limit/max where needed and format the speeds.
   owsm_scaler #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scaler (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mix_valid),
      .in_ready    (mix_ready),
      .in_data     (mix_data),
      .wheel_limit (limits_ff.wheel_limit),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .front_speed (rsp_chan.front_speed),
      .left_speed  (rsp_chan.left_speed),
      .right_speed (rsp_chan.right_speed),
      .was_scaled  (rsp_chan.was_scaled)
   );

   // Checking aids: items in flight and output magnitudes.
   logic [CNT_W-1:0] occupancy_ff, occupancy_in;
   logic             req_xfer;
   logic             rsp_xfer;
   logic [CHK_W-1:0] spd_mag [3];
   logic [CHK_W-1:0] spd_bound;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      occupancy_in = occupancy_ff;
      if (req_xfer && !rsp_xfer) begin
         occupancy_in = occupancy_ff + CNT_W'(1);
      end else if (!req_xfer && rsp_xfer) begin
         occupancy_in = occupancy_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   always_comb begin
      spd_mag[0] = rsp_chan.front_speed[OUT_W-1] ? -CHK_W'(rsp_chan.front_speed)
                                                 : CHK_W'(rsp_chan.front_speed);
      spd_mag[1] = rsp_chan.left_speed[OUT_W-1] ? -CHK_W'(rsp_chan.left_speed)
                                                : CHK_W'(rsp_chan.left_speed);
      spd_mag[2] = rsp_chan.right_speed[OUT_W-1] ? -CHK_W'(rsp_chan.right_speed)
                                                 : CHK_W'(rsp_chan.right_speed);
      spd_bound  = CHK_W'(limits_ff.wheel_limit) << FRAC_BITS;
   end

   // No wheel leaves the block above the wheel limit, scaled or not.
   a_wheel_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (spd_mag[0] <= spd_bound) && (spd_mag[1] <= spd_bound)
                         && (spd_mag[2] <= spd_bound))
      else $error("wheel speed above wheel limit");

   // A result is only offered for a command that was taken and not yet delivered.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (occupancy_ff != '0))
      else $error("result offered with nothing in flight");

   // The pipeline never holds more items than it has stages.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= CNT_W'(DEPTH))
      else $error("more items in flight than pipeline stages");

endmodule

[hdl/owsm_mixer.sv]
// Clamp, mix, magnitude and maximum stages of the omni wheel speed mixer.
module owsm_mixer import owsm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [CMD_W-1:0] cmd_vx,
   input  logic signed [CMD_W-1:0] cmd_vy,
   input  logic signed [CMD_W-1:0] cmd_vw,
   input  limits_type              limits,
   output logic                    out_valid,
   input  logic                    out_ready,
   output mix_type                 out_data
);

   localparam int MS = MIX_STAGES;

   logic [MS-1:0] valid_ff;
   logic [MS-1:0] valid_in;
   logic [MS:0]   rdy;

   logic signed [CMD_W-1:0]   vx_ff, vy_ff, vw_ff;
   logic signed [CMD_W+1:0]   front_sum_ff, front_sum_in;
   logic signed [CMD_W:0]     diff_ff, diff_in;
   logic signed [2*CMD_W-2:0] prod_ff, prod_in;
   logic signed [WHEEL_W-1:0] wheel_ff [3];
   logic signed [WHEEL_W-1:0] wheel_in [3];
   logic [MAG_W-1:0]          mag_ff [3];
   logic [MAG_W-1:0]          mag_in [3];
   logic [2:0]                neg_ff, neg_in;
   mix_type                   out_ff, out_in;

   function automatic logic signed [CMD_W-1:0] clamp_cmd(
      input logic signed [CMD_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [CMD_W:0] lim_pos;
      logic signed [CMD_W:0] lim_neg;
      logic signed [CMD_W:0] v_ext;
      lim_pos = signed'({2'b00, lim});
      lim_neg = -lim_pos;
      v_ext   = (CMD_W+1)'(v);
      if (v_ext > lim_pos) return lim_pos[CMD_W-1:0];
      if (v_ext < lim_neg) return lim_neg[CMD_W-1:0];
      return v;
   endfunction

   // A stage takes a new item when it is empty or its content moves on.
   always_comb begin
      rdy[MS] = out_ready;
      for (int k = MS - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < MS; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: clamp.
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         vx_ff <= clamp_cmd(cmd_vx, limits.limit_vx);
         vy_ff <= clamp_cmd(cmd_vy, limits.limit_vy);
         vw_ff <= clamp_cmd(cmd_vw, limits.limit_vw);
      end
   end

   // Stage 2: partial sums and the sqrt3 product.
   always_comb begin
      front_sum_in = ((CMD_W+2)'(vx_ff) <<< 1) + (CMD_W+2)'(vw_ff);
      diff_in      = (CMD_W+1)'(vw_ff) - (CMD_W+1)'(vx_ff);
      prod_in      = (2*CMD_W-1)'(vy_ff) * (2*CMD_W-1)'(SQRT3_Q14);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         front_sum_ff <= front_sum_in;
         diff_ff      <= diff_in;
         prod_ff      <= prod_in;
      end
   end

   // Stage 3: wheel values in Q14.
   always_comb begin
      wheel_in[0] = WHEEL_W'(front_sum_ff) <<< Q_IN;
      wheel_in[1] = (WHEEL_W'(diff_ff) <<< Q_IN) - WHEEL_W'(prod_ff);
      wheel_in[2] = (WHEEL_W'(diff_ff) <<< Q_IN) + WHEEL_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         wheel_ff <= wheel_in;
      end
   end

   // Stage 4: sign and magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = wheel_ff[i][WHEEL_W-1];
         mag_in[i] = MAG_W'(neg_in[i] ? -wheel_ff[i] : wheel_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // Stage 5: largest magnitude and the strict limit test.
   always_comb begin
      logic [MAG_W-1:0] max01;
      max01 = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      for (int i = 0; i < 3; i++) begin
         out_in.mag[i] = mag_ff[i];
      end
      out_in.neg   = neg_ff;
      out_in.maxq  = (max01 > mag_ff[2]) ? max01 : mag_ff[2];
      out_in.scale = out_in.maxq > MAG_W'({limits.wheel_limit, {Q_IN{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         out_ff <= out_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[MS-1];
   assign out_data  = out_ff;

endmodule

[hdl/owsm_div_lane.sv]
// One lane of the pipelined restoring divider: one quotient bit per stage.
module owsm_div_lane #(
   parameter int QW    = 23,
   parameter int DIV_W = 31
) (
   input  logic             clock,
   input  logic [QW-1:0]    en,
   input  logic [DIV_W-1:0] rem_init,
   input  logic [QW-1:0]    bits_init,
   input  logic [DIV_W-1:0] divisor [QW],
   output logic [QW-1:0]    quotient
);

   logic [DIV_W-1:0] rem_ff  [QW];
   logic [QW-1:0]    bits_ff [QW];

   // Dividend bits shift out at the top while quotient bits shift in below.
   for (genvar j = 0; j < QW; j++) begin : g_step
      logic [DIV_W-1:0] rem_src;
      logic [QW-1:0]    bits_src;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;
      logic             take;
      logic [DIV_W-1:0] rem_in;
      logic [QW-1:0]    bits_in;

      if (j == 0) begin : g_head
         assign rem_src  = rem_init;
         assign bits_src = bits_init;
      end else begin : g_body
         assign rem_src  = rem_ff[j-1];
         assign bits_src = bits_ff[j-1];
      end

      always_comb begin
         trial   = {rem_src, bits_src[QW-1]};
         diff    = trial - {1'b0, divisor[j]};
         take    = trial >= {1'b0, divisor[j]};
         rem_in  = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         bits_in = {bits_src[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]  <= rem_in;
            bits_ff[j] <= bits_in;
         end
      end
   end

   assign quotient = bits_ff[QW-1];

endmodule

[hdl/owsm_scaler.sv]
// Proportional scaling, output formatting and saturation stages.
module owsm_scaler import owsm_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  mix_type                 in_data,
   input  logic [LIM_W-1:0]        wheel_limit,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] front_speed,
   output logic signed [OUT_W-1:0] left_speed,
   output logic signed [OUT_W-1:0] right_speed,
   output logic                    was_scaled
);

   localparam int QW    = LIM_W + FRAC_BITS;           // quotient bits
   localparam int UW    = MAG_W - Q_IN + FRAC_BITS;    // unscaled magnitude bits
   localparam int NS    = QW + 2;                      // product, divide, output
   localparam int RW    = (UW > QW) ? UW : QW;
   localparam int EXT_W = ((RW > OUT_W) ? RW : OUT_W) + 1;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   rdy;

   logic [MUL_W-1:0] prod_ff [3];
   logic [MAG_W-1:0] maxq_ff [QW];
   logic             scale_ff [QW+1];
   logic [2:0]       neg_ff [QW+1];
   logic [UW-1:0]    unsc_ff [QW+1][3];
   logic [MAG_W-1:0] div_arr [QW];
   logic [QW-1:0]    quo [3];

   logic [OUT_W-1:0] speed_ff [3];
   logic [OUT_W-1:0] speed_in [3];
   logic             was_scaled_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Product stage: magnitude times wheel limit; unscaled value by truncation.
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i]    <= MUL_W'(in_data.mag[i]) * MUL_W'(wheel_limit);
            unsc_ff[0][i] <= UW'(in_data.mag[i] >> (Q_IN - FRAC_BITS));
         end
         maxq_ff[0]  <= in_data.maxq;
         scale_ff[0] <= in_data.scale;
         neg_ff[0]   <= in_data.neg;
      end
   end

   // Side data travels alongside the divider stages.
   for (genvar k = 1; k <= QW; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            scale_ff[k] <= scale_ff[k-1];
            neg_ff[k]   <= neg_ff[k-1];
            unsc_ff[k]  <= unsc_ff[k-1];
         end
      end
   end

   for (genvar k = 1; k < QW; k++) begin : g_divisor
      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            maxq_ff[k] <= maxq_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < QW; j++) begin
         div_arr[j] = maxq_ff[j];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      owsm_div_lane #(
         .QW    (QW),
         .DIV_W (MAG_W)
      ) u_div_lane (
         .clock     (clock),
         .en        (rdy[QW:1]),
         .rem_init  (prod_ff[i][MUL_W-1:LIM_W]),
         .bits_init (QW'(prod_ff[i][LIM_W-1:0]) << FRAC_BITS),
         .divisor   (div_arr),
         .quotient  (quo[i])
      );
   end

   // Output stage: pick scaled or unscaled, restore sign, saturate.
   always_comb begin
      logic [EXT_W-1:0] r;
      logic [EXT_W-1:0] r_neg;
      for (int i = 0; i < 3; i++) begin
         r     = scale_ff[QW] ? EXT_W'(quo[i]) : EXT_W'(unsc_ff[QW][i]);
         r_neg = -r;
         if (neg_ff[QW][i]) begin
            speed_in[i] = (r > EXT_W'(SPEED_MIN)) ? SPEED_MIN : r_neg[OUT_W-1:0];
         end else begin
            speed_in[i] = (r > EXT_W'(SPEED_MAX)) ? SPEED_MAX : r[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         speed_ff      <= speed_in;
         was_scaled_ff <= scale_ff[QW];
      end
   end

   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[NS-1];
   assign front_speed = signed'(speed_ff[0]);
   assign left_speed  = signed'(speed_ff[1]);
   assign right_speed = signed'(speed_ff[2]);
   assign was_scaled  = was_scaled_ff;

endmodule
